/* rtl/ppm_pkg.sv */
`timescale 1ns / 1ps

package ppm_pkg;

    localparam int SPRITE_SLOTS_DEF = 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 3;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;

    localparam logic [6:0] EMPTY_SLOT  = 7'd64;
    localparam logic [6:0] SPRITE_ZERO = 7'd0;
    localparam logic [7:0] LAST_COLUMN = 8'd255;

    // sprite_flags bit positions
    localparam int FLAG_BEHIND = 5;
    localparam int FLAG_HFLIP  = 6;

    typedef enum logic [1:0] {
        OP_RENDER      = 2'd0,
        OP_BG_TILE     = 2'd1,
        OP_SPRITE_LOAD = 2'd2,
        OP_CLEAR_HIT   = 2'd3
    } t_op;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BG_ENABLE       = 3'd0,
        CFG_SPRITE_ENABLE   = 3'd1,
        CFG_BG_LEFT_EDGE    = 3'd2,
        CFG_SPRITE_LEFT     = 3'd3,
        CFG_FINE_SCROLL_X   = 3'd4,
        CFG_COLOR_EMPHASIS  = 3'd5
    } t_cfg_reg;

    typedef struct packed {
        t_op        op;
        logic [7:0] column;
        logic [7:0] pattern_low;
        logic [7:0] pattern_high;
        logic [1:0] tile_palette;
        logic [2:0] slot;
        logic [6:0] sprite_index;
        logic [7:0] sprite_column;
        logic [7:0] sprite_flags;
    } t_item;

    typedef struct packed {
        logic       valid;
        logic [2:0] slot;
        logic [6:0] number;
        logic [7:0] column;
        logic [7:0] flags;
        logic [7:0] plane_low;
        logic [7:0] plane_high;
    } t_spr_load;

    typedef struct packed {
        logic       opaque;
        logic [3:0] pix;
        logic       behind;
        logic       zero_hit;
    } t_spr_pick;

endpackage

/* rtl/ppu_pixel_priority_mux.sv */
`timescale 1ns / 1ps

// Channel    Dir  Handshake               Payload
// s (in)     in   i_s_tvalid/o_s_tready   i_s_tdata (tile, sprite, column), i_s_tuser (op)
// m (out)    out  o_m_tvalid/i_m_tready   o_m_tdata (address, emphasis, hit flag)
// cfg        in   i_cfg_wr_en             i_cfg_addr, i_cfg_wdata
//
// One transaction per cycle while no pixel waits on a stall of m; a pixel result
// follows its input transaction through the input register, then the result register.
// Loads and hit-flag clears give no output transaction.
// Synchronous active-low reset empties both registers, clears the flag, the
// background shifters, config and marks every sprite slot empty.
// A stall on m holds the result and back-pressures s only when a pixel waits.
module ppu_pixel_priority_mux #(
    parameter int SPRITE_SLOTS = ppm_pkg::SPRITE_SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // from bit 0: column, pattern_low, pattern_high, tile_palette, slot,
    // sprite_index, sprite_column, sprite_flags, zero fill
    input  logic [ppm_pkg::S_TDATA_W-1:0] i_s_tdata,
    // op
    input  logic [ppm_pkg::S_TUSER_W-1:0] i_s_tuser,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // from bit 0: color_address, emphasis_out, zero_hit, zero fill
    output logic [ppm_pkg::M_TDATA_W-1:0] o_m_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    input  logic                          i_cfg_wr_en,
    input  logic [ppm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [ppm_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);

    // configuration
    logic       r_bg_en, r_spr_en, r_bg_left, r_spr_left;
    logic [2:0] r_fine_x, r_emphasis;

    // input stage
    logic           r_in_valid, n_in_valid;
    ppm_pkg::t_item r_item, w_item;

    // block state
    logic [15:0] r_bg_lo, r_bg_hi;
    logic [3:0]  r_bg_pair;
    logic        r_zero_hit, n_zero_hit;

    // result stage
    logic       r_out_valid, n_out_valid;
    logic [4:0] r_color;
    logic [2:0] r_emph_out;
    logic       r_hit_out;

    logic                 w_accept, w_fire, w_render;
    logic [3:0]           w_shift, w_bg_idx;
    logic [1:0]           w_bg_pix;
    logic [3:0]           w_bg_color;
    logic [4:0]           w_color;
    logic                 w_left_cols, w_spr_active;
    ppm_pkg::t_spr_load   w_load;
    ppm_pkg::t_spr_pick   w_pick;

    assign w_item = ppm_pkg::t_item'{
        op:            ppm_pkg::t_op'(i_s_tuser[1:0]),
        column:        i_s_tdata[7:0],
        pattern_low:   i_s_tdata[15:8],
        pattern_high:  i_s_tdata[23:16],
        tile_palette:  i_s_tdata[25:24],
        slot:          i_s_tdata[28:26],
        sprite_index:  i_s_tdata[35:29],
        sprite_column: i_s_tdata[43:36],
        sprite_flags:  i_s_tdata[51:44]
    };

    assign w_render   = r_item.op == ppm_pkg::OP_RENDER;
    assign w_fire     = r_in_valid && (!w_render || !r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_fire;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bg_en    <= 1'b0;
            r_spr_en   <= 1'b0;
            r_bg_left  <= 1'b0;
            r_spr_left <= 1'b0;
            r_fine_x   <= 3'd0;
            r_emphasis <= 3'd0;
        end else if (i_cfg_wr_en) begin
            case (ppm_pkg::t_cfg_reg'(i_cfg_addr))
                ppm_pkg::CFG_BG_ENABLE:      r_bg_en    <= i_cfg_wdata[0];
                ppm_pkg::CFG_SPRITE_ENABLE:  r_spr_en   <= i_cfg_wdata[0];
                ppm_pkg::CFG_BG_LEFT_EDGE:   r_bg_left  <= i_cfg_wdata[0];
                ppm_pkg::CFG_SPRITE_LEFT:    r_spr_left <= i_cfg_wdata[0];
                ppm_pkg::CFG_FINE_SCROLL_X:  r_fine_x   <= i_cfg_wdata;
                ppm_pkg::CFG_COLOR_EMPHASIS: r_emphasis <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // background pixel: bit (15 - fine_x - column[2:0]) of the shifters;
    // the upper tile's palette applies while that bit sits in the top byte
    always_comb begin
        w_left_cols = r_item.column[7:3] == 5'd0;
        w_shift     = {1'b0, r_fine_x} + {1'b0, r_item.column[2:0]};
        w_bg_idx    = 4'd15 - w_shift;
        w_bg_pix    = {r_bg_hi[w_bg_idx], r_bg_lo[w_bg_idx]};
        if (!r_bg_en || (!r_bg_left && w_left_cols)) begin
            w_bg_pix = 2'd0;
        end
        w_bg_color = {(w_shift[3] ? r_bg_pair[1:0] : r_bg_pair[3:2]), w_bg_pix};
        if (w_bg_pix == 2'd0) begin
            w_bg_color = 4'd0;
        end
        w_spr_active = r_spr_en && (r_spr_left || !w_left_cols);
    end

    assign w_load = ppm_pkg::t_spr_load'{
        valid:      w_fire && r_item.op == ppm_pkg::OP_SPRITE_LOAD,
        slot:       r_item.slot,
        number:     r_item.sprite_index,
        column:     r_item.sprite_column,
        flags:      r_item.sprite_flags,
        plane_low:  r_item.pattern_low,
        plane_high: r_item.pattern_high
    };

    ppm_sprite_bank #(
        .SPRITE_SLOTS (SPRITE_SLOTS)
    ) u_sprites (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (w_load),
        .i_column    (r_item.column),
        .i_active    (w_spr_active),
        .i_bg_opaque (w_bg_pix != 2'd0),
        .o_result    (w_pick)
    );

    always_comb begin
        if (w_pick.opaque && (w_bg_pix == 2'd0 || !w_pick.behind)) begin
            w_color = {1'b1, w_pick.pix};
        end else begin
            w_color = {1'b0, w_bg_color};
        end
    end

    always_comb begin
        n_in_valid = r_in_valid;
        if (w_accept) begin
            n_in_valid = 1'b1;
        end else if (w_fire) begin
            n_in_valid = 1'b0;
        end

        n_out_valid = r_out_valid && !i_m_tready;
        if (w_fire && w_render) begin
            n_out_valid = 1'b1;
        end

        n_zero_hit = r_zero_hit;
        if (w_fire) begin
            case (r_item.op)
                ppm_pkg::OP_RENDER:    n_zero_hit = r_zero_hit | w_pick.zero_hit;
                ppm_pkg::OP_CLEAR_HIT: n_zero_hit = 1'b0;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_zero_hit  <= 1'b0;
            r_bg_lo     <= 16'd0;
            r_bg_hi     <= 16'd0;
            r_bg_pair   <= 4'd0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            r_zero_hit  <= n_zero_hit;
            if (w_fire && r_item.op == ppm_pkg::OP_BG_TILE) begin
                r_bg_lo   <= {r_bg_lo[7:0], r_item.pattern_low};
                r_bg_hi   <= {r_bg_hi[7:0], r_item.pattern_high};
                r_bg_pair <= {r_bg_pair[1:0], r_item.tile_palette};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= w_item;
        end
        if (w_fire && w_render) begin
            r_color    <= w_color;
            r_emph_out <= r_emphasis;
            r_hit_out  <= n_zero_hit;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_hit_out, r_emph_out, r_color};

    a_render_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_render) |=> r_out_valid)
        else $error("rendered pixel did not reach the result register");

    a_clear_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_item.op == ppm_pkg::OP_CLEAR_HIT) |=> !r_zero_hit)
        else $error("hit flag not cleared");

    a_no_hit_last_column: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_render && r_item.column == ppm_pkg::LAST_COLUMN)
        |=> (r_zero_hit == $past(r_zero_hit)))
        else $error("hit flag changed at the last column");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !(w_fire && w_render))
        else $error("pending result overwritten");

endmodule

/* rtl/ppm_sprite_bank.sv */
`timescale 1ns / 1ps

module ppm_sprite_bank #(
    parameter int SPRITE_SLOTS = ppm_pkg::SPRITE_SLOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ppm_pkg::t_spr_load i_load,
    input  logic [7:0]         i_column,
    input  logic               i_active,
    input  logic               i_bg_opaque,
    output ppm_pkg::t_spr_pick o_result
);

    logic [6:0] r_number     [SPRITE_SLOTS];
    logic [7:0] r_column     [SPRITE_SLOTS];
    logic [7:0] r_flags      [SPRITE_SLOTS];
    logic [7:0] r_plane_low  [SPRITE_SLOTS];
    logic [7:0] r_plane_high [SPRITE_SLOTS];

    logic [SPRITE_SLOTS-1:0] w_opaque;
    logic [3:0]              w_pix [SPRITE_SLOTS];

    // slot numbers reset to empty; the other fields only matter once written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SPRITE_SLOTS; i++) begin
                r_number[i] <= ppm_pkg::EMPTY_SLOT;
            end
        end else begin
            for (int i = 0; i < SPRITE_SLOTS; i++) begin
                if (i_load.valid && int'(i_load.slot) == i) begin
                    r_number[i] <= i_load.number;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            if (i_load.valid && int'(i_load.slot) == i) begin
                r_column[i]     <= i_load.column;
                r_flags[i]      <= i_load.flags;
                r_plane_low[i]  <= i_load.plane_low;
                r_plane_high[i] <= i_load.plane_high;
            end
        end
    end

    // per-slot pixel fetch, all slots in parallel
    always_comb begin
        logic [8:0] dx;
        logic [2:0] col_idx;
        logic [2:0] bit_idx;
        logic       covers;
        for (int i = 0; i < SPRITE_SLOTS; i++) begin
            dx      = {1'b0, i_column} - {1'b0, r_column[i]};
            covers  = !dx[8] && (dx[7:3] == 5'd0) && (r_number[i] != ppm_pkg::EMPTY_SLOT);
            col_idx = dx[2:0] ^ {3{r_flags[i][ppm_pkg::FLAG_HFLIP]}};
            bit_idx = 3'd7 - col_idx;
            w_pix[i]    = {r_flags[i][1:0], r_plane_high[i][bit_idx], r_plane_low[i][bit_idx]};
            w_opaque[i] = i_active && covers && (w_pix[i][1:0] != 2'd0);
        end
    end

    // lowest opaque slot wins; a hit by sprite zero counts from any slot
    always_comb begin
        o_result = '0;
        for (int i = SPRITE_SLOTS - 1; i >= 0; i--) begin
            if (w_opaque[i]) begin
                o_result.opaque = 1'b1;
                o_result.pix    = w_pix[i];
                o_result.behind = r_flags[i][ppm_pkg::FLAG_BEHIND];
                if (r_number[i] == ppm_pkg::SPRITE_ZERO && i_bg_opaque
                        && i_column != ppm_pkg::LAST_COLUMN) begin
                    o_result.zero_hit = 1'b1;
                end
            end
        end
    end

    a_opaque_needs_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.opaque |-> i_active)
        else $error("sprite pixel picked while sprite layer inactive");

    a_hit_needs_opaque: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.zero_hit |-> o_result.opaque)
        else $error("sprite zero hit without an opaque sprite pixel");

    a_hit_conditions: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.zero_hit |-> (i_bg_opaque && i_column != ppm_pkg::LAST_COLUMN))
        else $error("sprite zero hit without opaque background or at last column");

endmodule

/* tb/tb_ppu_pixel_priority_mux.sv */
`timescale 1ns / 1ps

module tb_ppu_pixel_priority_mux;
    import ppm_pkg::*;

    localparam int SLOTS       = SPRITE_SLOTS_DEF;
    localparam int STALL_LIMIT = 1000;
    localparam int PIPE_FLUSH  = 4;
    localparam int BOOT_ROWS   = 3;
    localparam int BLOCKS      = 11;
    localparam int BLOCK_ITEMS = 100;

    typedef struct packed {
        logic [4:0] addr;
        logic [2:0] emph;
        logic       hit;
    } t_pixel;

    typedef struct packed {
        logic       bg_en;
        logic       spr_en;
        logic       bg_left;
        logic       spr_left;
        logic [2:0] scroll;
        logic [2:0] emph;
    } t_settings;

    typedef struct {
        t_item  it;
        logic   pin;
        t_pixel px;
    } t_row;

    localparam t_pixel BLANK_PX = '0;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic [S_TUSER_W-1:0]  s_tuser = '0;
    logic                  s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  o_m_tvalid;
    logic                  m_tready = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // sideband travelling with the driven transaction
    t_item  drv_item = '0;
    logic   pin_valid = 1'b0;
    t_pixel pin_px = '0;

    // pixel stage mirror
    t_settings  cfg = '0;
    logic [15:0] bg_lo_sr, bg_hi_sr;
    logic [3:0]  bg_pal_sr;
    logic [6:0]  spr_num   [SLOTS];
    logic [7:0]  spr_col   [SLOTS];
    logic [7:0]  spr_flags [SLOTS];
    logic [7:0]  spr_lo    [SLOTS];
    logic [7:0]  spr_hi    [SLOTS];
    logic        hit_flag;

    t_pixel pixel_due_q[$];
    t_row   dir_rows[$];
    int     errs = 0;
    int     quiet = 0;
    int     src_idle_pct = 0;
    int     snk_idle_pct = 0;
    logic [7:0] hot_col = '0;

    ppu_pixel_priority_mux dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_s_tdata   (s_tdata),
        .i_s_tuser   (s_tuser),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (m_tready),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Colour of one pixel; also updates the sticky sprite zero hit flag.
    function automatic logic [4:0] shade_pixel(input logic [7:0] x);
        logic [3:0]  sh;
        logic [15:0] tap;
        logic [3:0]  bg;
        logic [4:0]  obj;
        logic        behind;
        logic [7:0]  dx;
        logic [2:0]  px_col;
        logic [1:0]  pix;
        int          s;
        sh  = {1'b0, cfg.scroll} + {1'b0, x[2:0]};
        tap = 16'h8000 >> sh;
        bg  = {2'b00, |(bg_hi_sr & tap), |(bg_lo_sr & tap)};
        if (bg != 4'd0) begin
            bg[3:2] = (tap[15:8] != 8'd0) ? bg_pal_sr[3:2] : bg_pal_sr[1:0];
        end
        if (!cfg.bg_en || (!cfg.bg_left && x < 8'd8)) bg = 4'd0;
        obj    = 5'd0;
        behind = 1'b0;
        if (cfg.spr_en && !(!cfg.spr_left && x < 8'd8)) begin
            // walk downwards so the lowest opaque slot is the last to land
            for (s = SLOTS - 1; s >= 0; s--) begin
                dx = x - spr_col[s];
                if (spr_num[s] == EMPTY_SLOT || x < spr_col[s] || dx >= 8'd8) continue;
                px_col = spr_flags[s][FLAG_HFLIP] ? ~dx[2:0] : dx[2:0];
                pix = {spr_hi[s][3'd7 - px_col], spr_lo[s][3'd7 - px_col]};
                if (pix == 2'd0) continue;
                if (spr_num[s] == SPRITE_ZERO && bg != 4'd0 && x != LAST_COLUMN) begin
                    hit_flag = 1'b1;
                end
                obj    = {1'b1, spr_flags[s][1:0], pix};
                behind = spr_flags[s][FLAG_BEHIND];
            end
        end
        if (!cfg.bg_en && !cfg.spr_en) return 5'd0;
        if (obj[4] && (bg == 4'd0 || !behind)) return obj;
        return {1'b0, bg};
    endfunction

    task automatic take_item(input t_item it, input logic pinned, input t_pixel fixed);
        t_pixel px;
        case (it.op)
            OP_RENDER: begin
                px.addr = shade_pixel(it.column);
                px.emph = cfg.emph;
                px.hit  = hit_flag;
                pixel_due_q.push_back(pinned ? fixed : px);
            end
            OP_BG_TILE: begin
                bg_lo_sr  = {bg_lo_sr[7:0], it.pattern_low};
                bg_hi_sr  = {bg_hi_sr[7:0], it.pattern_high};
                bg_pal_sr = {bg_pal_sr[1:0], it.tile_palette};
            end
            OP_SPRITE_LOAD: begin
                if (it.slot < SLOTS) begin
                    spr_num[it.slot]   = it.sprite_index;
                    spr_col[it.slot]   = it.sprite_column;
                    spr_flags[it.slot] = it.sprite_flags;
                    spr_lo[it.slot]    = it.pattern_low;
                    spr_hi[it.slot]    = it.pattern_high;
                end
            end
            OP_CLEAR_HIT: begin
                hit_flag = 1'b0;
            end
            default: ;
        endcase
    endtask

    task automatic check_pixel(input logic [M_TDATA_W-1:0] d);
        t_pixel want;
        if (pixel_due_q.size() == 0) begin
            $error("unexpected pixel transaction, tdata %h", d);
            errs++;
            return;
        end
        want = pixel_due_q.pop_front();
        if (d[4:0] != want.addr) begin
            $error("color_address: expected %0d, got %0d", want.addr, d[4:0]);
            errs++;
        end
        if (d[7:5] != want.emph) begin
            $error("emphasis_out: expected %0d, got %0d", want.emph, d[7:5]);
            errs++;
        end
        if (d[8] != want.hit) begin
            $error("zero_hit: expected %0d, got %0d", want.hit, d[8]);
            errs++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n) begin
            if (o_m_tvalid && m_tready) check_pixel(o_m_tdata);
            if (s_tvalid && o_s_tready) take_item(drv_item, pin_valid, pin_px);
        end
    end

    always @(posedge clk) begin
        m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready)) quiet <= 0;
        else quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_item(input t_item it, input logic pinned, input t_pixel fixed);
        int gap;
        gap = 0;
        while (gap < 20 && $urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid  <= 1'b1;
        s_tdata   <= {4'b0, it.sprite_flags, it.sprite_column, it.sprite_index, it.slot,
                      it.tile_palette, it.pattern_high, it.pattern_low, it.column};
        s_tuser   <= it.op;
        drv_item  <= it;
        pin_valid <= pinned;
        pin_px    <= fixed;
        @(posedge clk);
        while (!o_s_tready) @(posedge clk);
    endtask

    // Stop sending, let every pixel come out and the pipeline empty.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pixel_due_q.size() != 0) @(posedge clk);
        repeat (PIPE_FLUSH) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg r, input logic [2:0] v);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge clk);
        case (r)
            CFG_BG_ENABLE:      cfg.bg_en    = v[0];
            CFG_SPRITE_ENABLE:  cfg.spr_en   = v[0];
            CFG_BG_LEFT_EDGE:   cfg.bg_left  = v[0];
            CFG_SPRITE_LEFT:    cfg.spr_left = v[0];
            CFG_FINE_SCROLL_X:  cfg.scroll   = v;
            CFG_COLOR_EMPHASIS: cfg.emph     = v;
            default: ;
        endcase
    endtask

    task automatic apply_settings(input t_settings v);
        write_reg(CFG_BG_ENABLE, {2'b00, v.bg_en});
        write_reg(CFG_SPRITE_ENABLE, {2'b00, v.spr_en});
        write_reg(CFG_BG_LEFT_EDGE, {2'b00, v.bg_left});
        write_reg(CFG_SPRITE_LEFT, {2'b00, v.spr_left});
        write_reg(CFG_FINE_SCROLL_X, v.scroll);
        write_reg(CFG_COLOR_EMPHASIS, v.emph);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic t_settings rand_settings();
        t_settings v;
        // layers mostly on so that priority and hits get exercised
        v.bg_en    = ($urandom_range(0, 4) != 0);
        v.spr_en   = ($urandom_range(0, 4) != 0);
        v.bg_left  = 1'($urandom_range(0, 1));
        v.spr_left = 1'($urandom_range(0, 1));
        v.scroll   = 3'($urandom_range(0, 7));
        v.emph     = 3'($urandom_range(0, 7));
        return v;
    endfunction

    function automatic t_item item_of(t_op op, int col, int plo, int phi, int pal,
                                      int slot, int idx, int scol, int flags);
        t_item it;
        it.op            = op;
        it.column        = 8'(col);
        it.pattern_low   = 8'(plo);
        it.pattern_high  = 8'(phi);
        it.tile_palette  = 2'(pal);
        it.slot          = 3'(slot);
        it.sprite_index  = 7'(idx);
        it.sprite_column = 8'(scol);
        it.sprite_flags  = 8'(flags);
        return it;
    endfunction

    function automatic void add_row(t_item it, logic pin, t_pixel px);
        t_row r;
        r.it  = it;
        r.pin = pin;
        r.px  = px;
        dir_rows.push_back(r);
    endfunction

    function automatic t_item rand_item();
        t_item it;
        int    r;
        it.column        = 8'($urandom_range(0, 255));
        it.pattern_low   = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
        it.pattern_high  = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom);
        it.tile_palette  = 2'($urandom_range(0, 3));
        it.slot          = 3'($urandom_range(0, SLOTS - 1));
        it.sprite_column = 8'($urandom_range(0, 255));
        it.sprite_flags  = 8'($urandom_range(0, 255));
        r = $urandom_range(0, 99);
        if (r < 25)      it.sprite_index = SPRITE_ZERO;
        else if (r < 40) it.sprite_index = EMPTY_SLOT;
        else if (r < 50) it.sprite_index = 7'($urandom_range(65, 127));
        else             it.sprite_index = 7'($urandom_range(1, 63));
        r = $urandom_range(0, 99);
        if (r < 45) begin
            it.op = OP_RENDER;
            // aim half the pixels at the latest sprite so that they overlap
            if ($urandom_range(0, 1) != 0) it.column = hot_col + 8'($urandom_range(0, 9));
        end else if (r < 70) begin
            it.op = OP_BG_TILE;
        end else if (r < 96) begin
            it.op   = OP_SPRITE_LOAD;
            hot_col = it.sprite_column;
        end else begin
            it.op = OP_CLEAR_HIT;
        end
        return it;
    endfunction

    initial begin
        bg_lo_sr  = '0;
        bg_hi_sr  = '0;
        bg_pal_sr = '0;
        hit_flag  = 1'b0;
        for (int i = 0; i < SLOTS; i++) begin
            spr_num[i]   = EMPTY_SLOT;
            spr_col[i]   = '0;
            spr_flags[i] = '0;
            spr_lo[i]    = '0;
            spr_hi[i]    = '0;
        end

        // under reset settings every pixel is blank
        add_row(item_of(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0), 1'b1, BLANK_PX);
        add_row(item_of(OP_RENDER, 255, 255, 255, 3, 7, 127, 255, 255), 1'b1, BLANK_PX);
        add_row(item_of(OP_CLEAR_HIT, 255, 255, 255, 3, 7, 127, 255, 255), 1'b0, BLANK_PX);
        // everything on from here
        add_row(item_of(OP_BG_TILE, 0, 8'hFF, 8'h00, 3, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_BG_TILE, 0, 8'h00, 8'hFF, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 15, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 7, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        // sprite zero behind an opaque background
        add_row(item_of(OP_SPRITE_LOAD, 0, 8'h80, 8'h80, 0, 0, 0, 8, 8'h23), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 8, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_CLEAR_HIT, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 200, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        // high sprite number, flipped, near the right edge
        add_row(item_of(OP_SPRITE_LOAD, 0, 8'h01, 8'h00, 0, 7, 127, 250, 8'h40), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 250, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 255, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        // sprite zero clipped at the last column, unused flag bits set: no hit there
        add_row(item_of(OP_SPRITE_LOAD, 0, 8'hFF, 8'hFF, 0, 1, 0, 255, 8'hDC), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 255, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        // empty slot must not show
        add_row(item_of(OP_SPRITE_LOAD, 0, 8'hFF, 8'hFF, 0, 2, 64, 0, 8'h00), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 0, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_SPRITE_LOAD, 0, 8'hFF, 8'h00, 0, 3, 5, 0, 8'h03), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 3, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_BG_TILE, 0, 8'h55, 8'hAA, 2, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 200, 0, 0, 0, 0, 0, 0, 0), 1'b0, BLANK_PX);
        add_row(item_of(OP_RENDER, 255, 255, 255, 3, 7, 127, 255, 255), 1'b0, BLANK_PX);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct = 35;
        snk_idle_pct = 75;
        for (int i = 0; i < dir_rows.size(); i++) begin
            if (i == BOOT_ROWS) begin
                drain();
                apply_settings('{1'b1, 1'b1, 1'b1, 1'b1, 3'd0, 3'd5});
            end
            send_item(dir_rows[i].it, dir_rows[i].pin, dir_rows[i].px);
        end

        for (int b = 0; b < BLOCKS; b++) begin
            drain();
            case (b)
                0:       apply_settings('{1'b1, 1'b1, 1'b1, 1'b1, 3'd7, 3'd7});
                1:       apply_settings('{1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 3'd0});
                2:       apply_settings('{1'b1, 1'b1, 1'b0, 1'b0, 3'd3, 3'd2});
                3:       apply_settings('{1'b1, 1'b0, 1'b1, 1'b0, 3'd5, 3'd1});
                default: apply_settings(rand_settings());
            endcase
            src_idle_pct = (b < 4) ? 35 : (b < 8) ? 75 : 0;
            snk_idle_pct = (b < 4) ? 75 : (b < 8) ? 35 : 0;
            repeat (BLOCK_ITEMS) send_item(rand_item(), 1'b0, BLANK_PX);
        end

        drain();
        if (errs == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ppm_pkg.sv
rtl/ppm_sprite_bank.sv
rtl/ppu_pixel_priority_mux.sv
tb/tb_ppu_pixel_priority_mux.sv
